// File: rtl/gss_pkg.sv
// ----------------------------------------------------------------------------
// Golden-section search package
// Shared types, codes and constants of the golden-section line search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gss_pkg;

    localparam logic [31:0] INV_PHI_Q32 = 32'd2654435769;
    localparam logic [63:0] ROUND_HALF  = 64'h0000_0000_8000_0000;
    localparam logic [30:0] TOL_RESET   = 31'd655;
    localparam logic [30:0] TOL_MIN     = 31'd1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_VALUE = 1'b1;

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef enum logic [1:0] {
        PEND_IDLE  = 2'd0,
        PEND_FIRST = 2'd1,
        PEND_RIGHT = 2'd2,
        PEND_LEFT  = 2'd3
    } t_pend;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] left_point;
        logic signed [31:0] right_point;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;
        t_pend              pend;
    } t_state;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic signed [31:0] func_value;
    } t_item;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] query_point;
        logic signed [31:0] center_point;
        logic signed [31:0] final_lower;
        logic signed [31:0] final_upper;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/gss_golden.sv
// ----------------------------------------------------------------------------
// Golden-section point unit
// Computes the interval length, the golden step, the next interior point,
// the midpoint and the stop condition for one interval.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gss_golden (
    input  logic signed [31:0] i_lo,
    input  logic signed [31:0] i_hi,
    input  logic        [30:0] i_tolerance,
    input  logic               i_take_left,
    output logic signed [31:0] o_query,
    output logic signed [31:0] o_center,
    output logic               o_done
);

    logic signed [32:0] w_diff;
    logic signed [32:0] w_neg;
    logic        [31:0] w_len;
    logic        [63:0] w_prod;
    logic        [63:0] w_round;
    logic        [31:0] w_step;
    logic signed [33:0] w_left;
    logic signed [33:0] w_right;
    logic signed [32:0] w_sum;
    logic        [30:0] w_tol;

    assign w_diff  = {i_hi[31], i_hi} - {i_lo[31], i_lo};
    assign w_neg   = -w_diff;
    assign w_len   = w_diff[32] ? w_neg[31:0] : w_diff[31:0];

    assign w_prod  = {32'd0, w_len} * {32'd0, gss_pkg::INV_PHI_Q32};
    assign w_round = w_prod + gss_pkg::ROUND_HALF;
    assign w_step  = w_round[63:32];

    assign w_left  = {{2{i_hi[31]}}, i_hi} - $signed({2'b00, w_step});
    assign w_right = {{2{i_lo[31]}}, i_lo} + $signed({2'b00, w_step});
    assign o_query = gss_pkg::sat32(i_take_left ? w_left : w_right);

    assign w_sum    = {i_lo[31], i_lo} + {i_hi[31], i_hi};
    assign o_center = w_sum[32:1];

    assign w_tol  = (i_tolerance == 31'd0) ? gss_pkg::TOL_MIN : i_tolerance;
    assign o_done = (w_len <= {1'b0, w_tol});

endmodule

// File: rtl/gss_step.sv
// ----------------------------------------------------------------------------
// Golden-section step logic
// Applies one request to the search state and forms the next state and the
// result, if the request produces one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gss_step (
    input  gss_pkg::t_state  i_state,
    input  gss_pkg::t_item   i_item,
    input  logic [30:0]      i_tolerance,
    output gss_pkg::t_state  o_state,
    output logic             o_emit,
    output gss_pkg::t_result o_result
);

    logic signed [31:0] w_lo;
    logic signed [31:0] w_hi;
    logic               w_take_left;
    logic signed [31:0] w_lv;
    logic signed [31:0] w_rv;
    logic               w_drop_left;
    logic signed [31:0] w_query;
    logic signed [31:0] w_center;
    logic               w_done;
    logic               w_fin;

    assign w_lv = (i_state.pend == gss_pkg::PEND_LEFT)  ? i_item.func_value
                                                        : i_state.left_value;
    assign w_rv = (i_state.pend == gss_pkg::PEND_RIGHT) ? i_item.func_value
                                                        : i_state.right_value;
    assign w_drop_left = (w_lv >= w_rv);

    always_comb begin
        w_lo        = i_state.lo;
        w_hi        = i_state.hi;
        w_take_left = 1'b0;
        if (i_item.opcode == gss_pkg::OP_START) begin
            w_take_left = 1'b1;
            if (i_item.lower_bound <= i_item.upper_bound) begin
                w_lo = i_item.lower_bound;
                w_hi = i_item.upper_bound;
            end else begin
                w_lo = i_item.upper_bound;
                w_hi = i_item.lower_bound;
            end
        end else begin
            case (i_state.pend)
                gss_pkg::PEND_RIGHT, gss_pkg::PEND_LEFT: begin
                    if (w_drop_left) begin
                        w_lo = i_state.left_point;
                    end else begin
                        w_hi        = i_state.right_point;
                        w_take_left = 1'b1;
                    end
                end
                default: begin
                    w_take_left = 1'b0;
                end
            endcase
        end
    end

    gss_golden u_golden (
        .i_lo        (w_lo),
        .i_hi        (w_hi),
        .i_tolerance (i_tolerance),
        .i_take_left (w_take_left),
        .o_query     (w_query),
        .o_center    (w_center),
        .o_done      (w_done)
    );

    // The first value of a pair never ends the search.
    assign w_fin = w_done && !((i_item.opcode == gss_pkg::OP_VALUE) &&
                               (i_state.pend == gss_pkg::PEND_FIRST));

    always_comb begin
        o_state                  = i_state;
        o_emit                   = 1'b0;
        o_result.kind            = w_fin ? gss_pkg::KIND_DONE : gss_pkg::KIND_QUERY;
        o_result.query_point     = w_fin ? 32'sd0 : w_query;
        o_result.center_point    = w_center;
        o_result.final_lower     = w_lo;
        o_result.final_upper     = w_hi;
        if (i_item.opcode == gss_pkg::OP_START) begin
            o_emit     = 1'b1;
            o_state.lo = w_lo;
            o_state.hi = w_hi;
            if (w_fin) begin
                o_state.pend = gss_pkg::PEND_IDLE;
            end else begin
                o_state.left_point = w_query;
                o_state.pend       = gss_pkg::PEND_FIRST;
            end
        end else begin
            case (i_state.pend)
                gss_pkg::PEND_FIRST: begin
                    o_emit              = 1'b1;
                    o_state.left_value  = i_item.func_value;
                    o_state.right_point = w_query;
                    o_state.pend        = gss_pkg::PEND_RIGHT;
                end
                gss_pkg::PEND_RIGHT, gss_pkg::PEND_LEFT: begin
                    o_emit = 1'b1;
                    if (w_drop_left) begin
                        o_state.lo          = i_state.left_point;
                        o_state.left_point  = i_state.right_point;
                        o_state.left_value  = w_rv;
                        o_state.right_value = w_rv;
                        if (w_fin) begin
                            o_state.pend = gss_pkg::PEND_IDLE;
                        end else begin
                            o_state.right_point = w_query;
                            o_state.pend        = gss_pkg::PEND_RIGHT;
                        end
                    end else begin
                        o_state.hi          = i_state.right_point;
                        o_state.right_point = i_state.left_point;
                        o_state.right_value = w_lv;
                        o_state.left_value  = w_lv;
                        if (w_fin) begin
                            o_state.pend = gss_pkg::PEND_IDLE;
                        end else begin
                            o_state.left_point = w_query;
                            o_state.pend       = gss_pkg::PEND_LEFT;
                        end
                    end
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end
    end

endmodule

// File: rtl/golden_section_line_search.sv
// ----------------------------------------------------------------------------
// Golden-section line search
// A request is held in the input register, then its result is loaded into the
// result register, which drives the outputs. Throughput: one request per cycle
// while the reply side does not stall; the search state is updated in the same
// cycle that the result register is loaded, so a value may follow at once.
// Reset (synchronous, active low) empties both registers, idles the search and
// sets the tolerance to 655 (about 0.01 in Q16.16).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module golden_section_line_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic        [30:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic signed [31:0] i_lower_bound,
    input  logic signed [31:0] i_upper_bound,
    input  logic signed [31:0] i_func_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_kind,
    output logic signed [31:0] o_query_point,
    output logic signed [31:0] o_center_point,
    output logic signed [31:0] o_final_lower,
    output logic signed [31:0] o_final_upper
);

    logic             r_in_valid;
    gss_pkg::t_item   r_item;
    gss_pkg::t_state  r_state;
    logic             r_out_valid;
    gss_pkg::t_result r_result;
    logic [30:0]      r_tolerance;

    gss_pkg::t_state  n_state;
    gss_pkg::t_result n_result;
    logic             w_emit;
    logic             w_advance;
    logic             w_in_take;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    gss_step u_step (
        .i_state     (r_state),
        .i_item      (r_item),
        .i_tolerance (r_tolerance),
        .o_state     (n_state),
        .o_emit      (w_emit),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_tolerance <= gss_pkg::TOL_RESET;
        end else begin
            if (i_cfg_we) begin
                r_tolerance <= i_cfg_data;
            end
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.opcode      <= i_opcode;
            r_item.lower_bound <= i_lower_bound;
            r_item.upper_bound <= i_upper_bound;
            r_item.func_value  <= i_func_value;
        end
        if (w_advance && w_emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_result.kind;
    assign o_query_point  = r_result.query_point;
    assign o_center_point = r_result.center_point;
    assign o_final_lower  = r_result.final_lower;
    assign o_final_upper  = r_result.final_upper;

endmodule

// File: tb/sv/tb_golden_section_line_search.sv
// ----------------------------------------------------------------------------
// Golden-section line search testbench
// Plays the part of the external evaluator: it starts searches, answers the
// query points with a value from a chosen objective, and checks each reply
// against its own fixed-point prediction of the search. Directed tests cover
// the reset tolerance, bound extremes, reversed bounds, stray values, abandoned
// searches, equal values and the tolerance extremes. A long random test then
// runs many searches with random gaps on the request side and random stalls on
// the reply side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_golden_section_line_search;

    typedef enum int {
        SHAPE_VEE,
        SHAPE_PEAK,
        SHAPE_FLAT,
        SHAPE_NOISE
    } t_shape;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic        [30:0] i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic               i_opcode      = gss_pkg::OP_START;
    logic signed [31:0] i_lower_bound = '0;
    logic signed [31:0] i_upper_bound = '0;
    logic signed [31:0] i_func_value  = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic               o_kind;
    logic signed [31:0] o_query_point;
    logic signed [31:0] o_center_point;
    logic signed [31:0] o_final_lower;
    logic signed [31:0] o_final_upper;

    logic        [30:0] tolerance_q = gss_pkg::TOL_RESET;
    gss_pkg::t_pend     srch_pend   = gss_pkg::PEND_IDLE;
    logic signed [31:0] srch_lo     = '0;
    logic signed [31:0] srch_hi     = '0;
    logic signed [31:0] left_pt     = '0;
    logic signed [31:0] right_pt    = '0;
    logic signed [31:0] left_val    = '0;
    logic signed [31:0] right_val   = '0;
    logic signed [31:0] last_query  = '0;

    gss_pkg::t_result search_replies[$];
    int unsigned      answered_requests = 0;
    int unsigned      mismatch_count    = 0;
    bit               no_idle           = 1'b0;

    golden_section_line_search uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_lower_bound  (i_lower_bound),
        .i_upper_bound  (i_upper_bound),
        .i_func_value   (i_func_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_query_point  (o_query_point),
        .o_center_point (o_center_point),
        .o_final_lower  (o_final_lower),
        .o_final_upper  (o_final_upper)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    function automatic longint span_len();
        longint d;
        d = longint'(srch_hi) - longint'(srch_lo);
        return (d < 0) ? -d : d;
    endfunction

    function automatic longint golden_step();
        logic [63:0] prod;
        prod = 64'(span_len()) * {32'd0, gss_pkg::INV_PHI_Q32} + gss_pkg::ROUND_HALF;
        return longint'({32'd0, prod[63:32]});
    endfunction

    function automatic bit search_done();
        longint stop_len;
        stop_len = (tolerance_q == '0) ? 64'sd1 : longint'({33'd0, tolerance_q});
        return span_len() <= stop_len;
    endfunction

    function automatic gss_pkg::t_result make_reply(input logic kind,
                                                    input logic signed [31:0] q);
        gss_pkg::t_result r;
        longint           s;
        s              = longint'(srch_lo) + longint'(srch_hi);
        r.kind         = kind;
        r.query_point  = q;
        r.center_point = 32'(s >>> 1);
        r.final_lower  = srch_lo;
        r.final_upper  = srch_hi;
        if (kind == gss_pkg::KIND_QUERY) begin
            last_query = q;
        end
        return r;
    endfunction

    function automatic gss_pkg::t_result finish_search();
        srch_pend = gss_pkg::PEND_IDLE;
        return make_reply(gss_pkg::KIND_DONE, '0);
    endfunction

    // Advances the search by one request; returns 0 when the request is ignored.
    function automatic bit step_search(input gss_pkg::t_item it,
                                       output gss_pkg::t_result r);
        r = '0;
        if (it.opcode == gss_pkg::OP_START) begin
            if (it.lower_bound <= it.upper_bound) begin
                srch_lo = it.lower_bound;
                srch_hi = it.upper_bound;
            end else begin
                srch_lo = it.upper_bound;
                srch_hi = it.lower_bound;
            end
            if (search_done()) begin
                r = finish_search();
            end else begin
                left_pt   = clamp32(longint'(srch_hi) - golden_step());
                srch_pend = gss_pkg::PEND_FIRST;
                r         = make_reply(gss_pkg::KIND_QUERY, left_pt);
            end
            return 1'b1;
        end
        if (srch_pend == gss_pkg::PEND_IDLE) begin
            return 1'b0;
        end
        if (srch_pend == gss_pkg::PEND_FIRST) begin
            left_val  = it.func_value;
            right_pt  = clamp32(longint'(srch_lo) + golden_step());
            srch_pend = gss_pkg::PEND_RIGHT;
            r         = make_reply(gss_pkg::KIND_QUERY, right_pt);
            return 1'b1;
        end
        if (srch_pend == gss_pkg::PEND_RIGHT) begin
            right_val = it.func_value;
        end else begin
            left_val = it.func_value;
        end
        if (left_val >= right_val) begin
            srch_lo  = left_pt;
            left_pt  = right_pt;
            left_val = right_val;
            if (search_done()) begin
                r = finish_search();
            end else begin
                right_pt  = clamp32(longint'(srch_lo) + golden_step());
                srch_pend = gss_pkg::PEND_RIGHT;
                r         = make_reply(gss_pkg::KIND_QUERY, right_pt);
            end
        end else begin
            srch_hi   = right_pt;
            right_pt  = left_pt;
            right_val = left_val;
            if (search_done()) begin
                r = finish_search();
            end else begin
                left_pt   = clamp32(longint'(srch_hi) - golden_step());
                srch_pend = gss_pkg::PEND_LEFT;
                r         = make_reply(gss_pkg::KIND_QUERY, left_pt);
            end
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            return 0;
        end else if (sel < 85) begin
            return $urandom_range(1, 3);
        end else if (sel < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] objective(input t_shape shape,
                                                     input logic signed [31:0] x,
                                                     input logic signed [31:0] target);
        longint d;
        d = longint'(x) - longint'(target);
        if (d < 0) begin
            d = -d;
        end
        case (shape)
            SHAPE_VEE:  return clamp32(d);
            SHAPE_PEAK: return clamp32(-d);
            SHAPE_FLAT: return target;
            default:    return $urandom;
        endcase
    endfunction

    task automatic send_request(input gss_pkg::t_item it);
        int               gap;
        gss_pkg::t_result want;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= it.opcode;
        i_lower_bound <= it.lower_bound;
        i_upper_bound <= it.upper_bound;
        i_func_value  <= it.func_value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (step_search(it, want)) begin
            search_replies.push_back(want);
            answered_requests++;
        end
    endtask

    task automatic send_start(input logic signed [31:0] a, input logic signed [31:0] b);
        send_request(gss_pkg::t_item'{opcode: gss_pkg::OP_START, lower_bound: a,
                                      upper_bound: b, func_value: $urandom});
    endtask

    task automatic send_value(input logic signed [31:0] v);
        send_request(gss_pkg::t_item'{opcode: gss_pkg::OP_VALUE, lower_bound: $urandom,
                                      upper_bound: $urandom, func_value: v});
    endtask

    task automatic drain_results(input int settle);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (search_replies.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [30:0] tol);
        drain_results(4);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= tol;
        @(posedge i_clk);
        tolerance_q = tol;
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_search(input logic signed [31:0] a, input logic signed [31:0] b,
                              input t_shape shape, input int max_values);
        logic signed [31:0] target;
        longint             lo_l;
        longint             width;
        int                 n;
        lo_l   = (a <= b) ? longint'(a) : longint'(b);
        width  = (a <= b) ? longint'(b) - longint'(a) : longint'(a) - longint'(b);
        target = clamp32(lo_l + (width * longint'($urandom_range(0, 1000))) / 1000);
        send_start(a, b);
        n = 0;
        while (srch_pend != gss_pkg::PEND_IDLE && n < max_values) begin
            send_value(objective(shape, last_query, target));
            n++;
        end
    endtask

    task automatic check_reply();
        gss_pkg::t_result got;
        gss_pkg::t_result want;
        got = '{kind: o_kind, query_point: o_query_point, center_point: o_center_point,
                final_lower: o_final_lower, final_upper: o_final_upper};
        if (search_replies.size() == 0) begin
            if (mismatch_count < 10) begin
                $display("unexpected reply: kind %0d query %0d center %0d lo %0d hi %0d",
                         got.kind, got.query_point, got.center_point,
                         got.final_lower, got.final_upper);
            end
            mismatch_count++;
            return;
        end
        want = search_replies.pop_front();
        if (got.kind !== want.kind || got.query_point !== want.query_point ||
            got.center_point !== want.center_point ||
            got.final_lower !== want.final_lower || got.final_upper !== want.final_upper) begin
            if (mismatch_count < 10) begin
                $display("reply mismatch (expected/actual): kind %0d/%0d query %0d/%0d",
                         want.kind, got.kind, want.query_point, got.query_point);
                $display("    center %0d/%0d lo %0d/%0d hi %0d/%0d",
                         want.center_point, got.center_point, want.final_lower,
                         got.final_lower, want.final_upper, got.final_upper);
            end
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_reply();
        end
    end

    initial begin : reply_stall_gen
        int n;
        @(posedge i_clk);
        forever begin
            n = no_idle ? 0 : pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // The reset tolerance of 655 applies here.
    task automatic test_idle_and_short_starts();
        send_request(gss_pkg::t_item'{opcode: gss_pkg::OP_VALUE, lower_bound: 32'sh8000_0000,
                                      upper_bound: 32'sh7FFF_FFFF,
                                      func_value: 32'shFFFF_FFFF});
        send_start('0, '0);
        send_start(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_start(-32'sd100, 32'sd555);
        send_start(32'sd656, 32'sd0);
    endtask

    task automatic test_full_range_and_values();
        send_start(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh7FFF_FFFF);
        send_value('0);
        send_value('0);
        send_value(32'shFFFF_FFFF);
    endtask

    task automatic test_tolerance_extremes();
        write_tolerance('0);
        send_start('0, 32'sd1);
        run_search('0, 32'sd2, SHAPE_VEE, 10);
        write_tolerance(31'h7FFF_FFFF);
        run_search(32'sh8000_0000, 32'sh7FFF_FFFF, SHAPE_VEE, 10);
        write_tolerance(gss_pkg::TOL_MIN);
        run_search(32'sd3, -32'sd3, SHAPE_PEAK, 10);
    endtask

    task automatic test_random_searches();
        logic signed [31:0] a;
        logic signed [31:0] b;
        longint             delta;
        int unsigned        goal;
        int unsigned        searches;
        int unsigned        sel;
        t_shape             shape;
        int                 cap;
        goal     = answered_requests + 1400;
        searches = 0;
        while (answered_requests < goal) begin
            if (searches % 12 == 0) begin
                case ($urandom_range(0, 7))
                    0:       write_tolerance('0);
                    1:       write_tolerance(gss_pkg::TOL_MIN);
                    2:       write_tolerance(gss_pkg::TOL_RESET);
                    3:       write_tolerance(31'h7FFF_FFFF);
                    4:       write_tolerance(31'($urandom_range(1, 65536)));
                    5:       write_tolerance(31'($urandom));
                    default: write_tolerance(31'($urandom_range(2, 2000)));
                endcase
                no_idle = ($urandom_range(0, 3) == 0);
            end else if ($urandom_range(0, 15) == 0) begin
                drain_results(0);
            end
            searches++;
            if ($urandom_range(0, 19) == 0) begin
                send_value($urandom);
            end
            a   = $urandom;
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                delta = longint'($urandom) - longint'(a);
            end else if (sel < 75) begin
                delta = longint'($urandom_range(0, 32'h0010_0000));
            end else begin
                delta = longint'($urandom_range(0, 4096));
            end
            if ($urandom_range(0, 1)) begin
                delta = -delta;
            end
            b = clamp32(longint'(a) + delta);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: shape = SHAPE_VEE;
                4, 5:       shape = SHAPE_PEAK;
                6:          shape = SHAPE_FLAT;
                default:    shape = SHAPE_NOISE;
            endcase
            cap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 5)) : 1000;
            run_search(a, b, shape, cap);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_and_short_starts();
        test_full_range_and_values();
        test_tolerance_extremes();
        test_random_searches();
        no_idle = 1'b0;
        drain_results(10);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
rtl/gss_pkg.sv
rtl/gss_golden.sv
rtl/gss_step.sv
rtl/golden_section_line_search.sv
tb/sv/tb_golden_section_line_search.sv
